FILE: rtl/dfhte_pkg.sv
// Package: command codes, deflate length/distance tables and fixed-code helpers.
package dfhte_pkg;

  typedef enum logic [1:0] {
    CMD_HEADER  = 2'd0,
    CMD_LITERAL = 2'd1,
    CMD_MATCH   = 2'd2,
    CMD_END     = 2'd3
  } cmd_e;

  localparam int unsigned NumLenSlots  = 29;
  localparam int unsigned NumDistSlots = 30;
  localparam int unsigned TokW         = 31;  // longest token: 8 + 5 + 5 + 13 bits
  localparam int unsigned TokLenW      = 5;

  localparam logic [8:0] MinMatchLen = 9'd3;
  localparam logic [8:0] MaxMatchLen = 9'd258;
  localparam logic [8:0] EobSym      = 9'd256;
  localparam logic [8:0] LenSymBase  = 9'd257;

  localparam logic [8:0] LEN_BASE [NumLenSlots] = '{
    9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15, 9'd17,
    9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67, 9'd83, 9'd99,
    9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
  };
  localparam logic [2:0] LEN_EXTRA [NumLenSlots] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd0
  };
  localparam logic [14:0] DIST_BASE [NumDistSlots] = '{
    15'd1, 15'd2, 15'd3, 15'd4, 15'd5, 15'd7, 15'd9, 15'd13, 15'd17, 15'd25,
    15'd33, 15'd49, 15'd65, 15'd97, 15'd129, 15'd193, 15'd257, 15'd385, 15'd513,
    15'd769, 15'd1025, 15'd1537, 15'd2049, 15'd3073, 15'd4097, 15'd6145,
    15'd8193, 15'd12289, 15'd16385, 15'd24577
  };
  localparam logic [3:0] DIST_EXTRA [NumDistSlots] = '{
    4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8, 4'd9, 4'd9, 4'd10, 4'd10,
    4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
  };

  typedef struct packed {
    logic [8:0] bits;  // stream order, first bit in bit 0
    logic [3:0] len;
  } code_t;

  // Fixed literal/length code, bit-reversed so it goes out MSB of the code first.
  function automatic code_t litlen_code(input logic [8:0] sym);
    logic [8:0] code;
    logic [3:0] n;
    logic [8:0] rev;
    code_t      res;
    if (sym < 9'd144) begin
      code = 9'h030 + sym;
      n    = 4'd8;
    end else if (sym < 9'd256) begin
      code = 9'h190 + (sym - 9'd144);
      n    = 4'd9;
    end else if (sym < 9'd280) begin
      code = sym - 9'd256;
      n    = 4'd7;
    end else begin
      code = 9'h0C0 + (sym - 9'd280);
      n    = 4'd8;
    end
    for (int i = 0; i < 9; i++) begin
      rev[i] = code[8 - i];
    end
    res.bits = rev >> (4'd9 - n);
    res.len  = n;
    return res;
  endfunction

  function automatic logic [4:0] rev5(input logic [4:0] v);
    logic [4:0] r;
    for (int i = 0; i < 5; i++) begin
      r[i] = v[4 - i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/deflate_fixed_huffman_token_encoder.sv
// Fixed-Huffman deflate token encoder: LZ77 tokens in, packed LSB-first bytes out.
// The first byte of an item passes the token register, the stage-2 bit-run register and
//   the output byte buffer before it shows on the output.
// Throughput: one item per cycle while the output is not stalled and each item completes
//   at most one byte; an item of k bytes (up to four) holds the output until all are taken.
// Reset clears all valid flags and the pending partial byte; payload registers are not reset.
module deflate_fixed_huffman_token_encoder #(
  parameter int unsigned MAX_DISTANCE = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // token requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  literal_byte_i,
  input  logic [8:0]  match_length_i,
  input  logic [15:0] match_distance_i,
  input  logic        final_block_i,
  // byte requests
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o
);
  import dfhte_pkg::*;

  localparam logic [15:0] MaxDist = 16'(MAX_DISTANCE);

  // ---------------------------------------------------------------------------
  // Stage 1: accepted token.
  // ---------------------------------------------------------------------------
  logic        s1_valid_q;
  cmd_e        s1_cmd_q;
  logic [7:0]  s1_lit_q;
  logic [8:0]  s1_len_q;
  logic [15:0] s1_dist_q;
  logic        s1_fin_q;
  logic        s1_adv;

  // ---------------------------------------------------------------------------
  // Stage 2: token as a run of stream bits, first bit in bit 0.
  // ---------------------------------------------------------------------------
  logic               s2_valid_q;
  logic [TokW-1:0]    s2_bits_q, s2_bits_d;
  logic [TokLenW-1:0] s2_len_q, s2_len_d;
  logic               s2_pad_q, s2_pad_d;
  logic               s2_adv;

  // Partial byte carried between tokens.
  logic [6:0] pend_bits_q, pend_bits_d;
  logic [2:0] pend_cnt_q, pend_cnt_d;

  // Output byte buffer: up to four completed bytes, oldest in the low byte.
  logic [31:0] obuf_q;
  logic [2:0]  ocnt_q;
  logic        out_take;
  logic        obuf_free;

  assign out_take   = out_valid_o && !out_stall_i;
  assign obuf_free  = (ocnt_q == 3'd0) || ((ocnt_q == 3'd1) && out_take);

  assign s1_adv     = s1_valid_q && (!s2_valid_q || s2_adv);
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Hold the payload while stalled; capture on every accepted request.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_cmd_q  <= cmd_e'(cmd_i);
      s1_lit_q  <= literal_byte_i;
      s1_len_q  <= match_length_i;
      s1_dist_q <= match_distance_i;
      s1_fin_q  <= final_block_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Token encoding: slot lookup, fixed codes and extra bits.
  // ---------------------------------------------------------------------------
  logic [8:0]  len_c;
  logic [15:0] dist_c;
  logic [4:0]  ls;
  logic [4:0]  ds;
  code_t       lit_code;
  code_t       lsym_code;
  code_t       eob_code;
  logic [4:0]  len_ext;
  logic [12:0] dist_ext;
  logic [4:0]  sh_len_ext;
  logic [4:0]  sh_dcode;
  logic [4:0]  sh_dext;

  always_comb begin
    // Clamp out-of-range match fields.
    len_c = s1_len_q;
    if (len_c < MinMatchLen) len_c = MinMatchLen;
    if (len_c > MaxMatchLen) len_c = MaxMatchLen;
    dist_c = s1_dist_q;
    if (dist_c == 16'd0) dist_c = 16'd1;
    if (dist_c > MaxDist) dist_c = MaxDist;

    // Highest slot whose base does not exceed the value; bases rise monotonically.
    ls = '0;
    for (int i = 1; i < NumLenSlots; i++) begin
      if (LEN_BASE[i] <= len_c) ls = 5'(i);
    end
    ds = '0;
    for (int i = 1; i < NumDistSlots; i++) begin
      if ({1'b0, DIST_BASE[i]} <= dist_c) ds = 5'(i);
    end

    lit_code   = litlen_code({1'b0, s1_lit_q});
    lsym_code  = litlen_code(LenSymBase + {4'd0, ls});
    eob_code   = litlen_code(EobSym);
    len_ext    = 5'(len_c - LEN_BASE[ls]);
    dist_ext   = 13'(dist_c - {1'b0, DIST_BASE[ds]});
    sh_len_ext = {1'b0, lsym_code.len};
    sh_dcode   = sh_len_ext + {2'd0, LEN_EXTRA[ls]};
    sh_dext    = sh_dcode + 5'd5;

    s2_bits_d = '0;
    s2_len_d  = '0;
    s2_pad_d  = 1'b0;
    case (s1_cmd_q)
      CMD_HEADER: begin
        // BFINAL then BTYPE=01, both sent LSB first.
        s2_bits_d = TokW'({1'b0, 1'b1, s1_fin_q});
        s2_len_d  = TokLenW'(3);
      end
      CMD_LITERAL: begin
        s2_bits_d = TokW'(lit_code.bits);
        s2_len_d  = TokLenW'(lit_code.len);
      end
      CMD_MATCH: begin
        s2_bits_d = TokW'(lsym_code.bits)
                  | (TokW'(len_ext) << sh_len_ext)
                  | (TokW'(rev5(ds)) << sh_dcode)
                  | (TokW'(dist_ext) << sh_dext);
        s2_len_d  = sh_dext + {1'b0, DIST_EXTRA[ds]};
      end
      CMD_END: begin
        // End-of-block code is seven zero bits; a final block pads to a byte.
        s2_bits_d = TokW'(eob_code.bits);
        s2_len_d  = TokLenW'(eob_code.len);
        s2_pad_d  = s1_fin_q;
      end
      default: begin
        s2_bits_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (!s2_valid_q || s2_adv) begin
      s2_valid_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_bits_q <= s2_bits_d;
      s2_len_q  <= s2_len_d;
      s2_pad_q  <= s2_pad_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Merge with the pending bits and split off the completed bytes.
  // ---------------------------------------------------------------------------
  logic [39:0] acc;
  logic [39:0] rest;
  logic [5:0]  n_raw;
  logic [5:0]  n_tot;
  logic [2:0]  nbytes;

  always_comb begin
    acc    = {33'd0, pend_bits_q} | ({9'd0, s2_bits_q} << pend_cnt_q);
    n_raw  = {3'd0, pend_cnt_q} + {1'b0, s2_len_q};
    n_tot  = s2_pad_q ? ((n_raw + 6'd7) & 6'b111000) : n_raw;
    nbytes = n_tot[5:3];
    rest   = acc >> {nbytes, 3'b000};
    pend_bits_d = rest[6:0];
    pend_cnt_d  = n_tot[2:0];
  end

  // A token that completes no byte passes without touching the output buffer.
  assign s2_adv = s2_valid_q && ((nbytes == 3'd0) || obuf_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else if (s2_adv) begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output byte buffer: load a run of bytes, advance one byte per taken request.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
    end else if (s2_adv && (nbytes != 3'd0)) begin
      ocnt_q <= nbytes;
    end else if (out_take) begin
      ocnt_q <= ocnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && (nbytes != 3'd0)) begin
      obuf_q <= acc[31:0];
    end else if (out_take) begin
      obuf_q <= {8'd0, obuf_q[31:8]};
    end
  end

  assign out_valid_o   = (ocnt_q != 3'd0);
  assign out_byte_o    = obuf_q[7:0];
  assign last_of_run_o = (ocnt_q == 3'd1);

endmodule
